[rtl/core/thread_slot_scheduler_defines.svh]
// ----------------------------------------------------------------------------
// Thread slot scheduler assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THREAD_SLOT_SCHEDULER_DEFINES_SVH
`define THREAD_SLOT_SCHEDULER_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define TSS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/tss_pkg.sv]
// ----------------------------------------------------------------------------
// Thread slot scheduler package
// Command, status, slot state and sequencer codes shared by the scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

   typedef enum logic [1:0] {
      CMD_CREATE  = 2'd0,
      CMD_YIELD   = 2'd1,
      CMD_DESTROY = 2'd2,
      CMD_SCHED   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_REFUSED = 2'd2,
      STATUS_NONE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_YIELD = 2'd2
   } slot_state_type;

   // selection policy codes; the fourth code selects nothing
   localparam logic [1:0] ALG_RR   = 2'd0;
   localparam logic [1:0] ALG_PRIO = 2'd1;
   localparam logic [1:0] ALG_FCFS = 2'd2;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_READ,
      SEQ_FINISH
   } seq_state_type;

   // control from the sequencer to the pick unit
   typedef struct packed {
      logic           clear;
      logic           sample;
      slot_state_type want;
      logic [1:0]     mode;
   } pick_ctrl_type;

endpackage

[rtl/core/thread_slot_scheduler.sv]
// ----------------------------------------------------------------------------
// Thread slot scheduler
// Table of thread slots with create, yield, destroy and schedule commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers on req_valid and req_ready; exactly one result
//   transfers on rsp_valid and rsp_ready for each command. csr_write_enable
//   writes the selection policy; write it only while the block is idle.
//   One command is worked at a time and req_ready is high only when idle.
//   Refusals and skipped schedules go straight to the final step; yield and
//   destroy read the current slot first; create and schedule scan the table,
//   and a schedule that finds no runnable slot scans again for yielded slots.
//   Each scan walks slots 1 to SLOTS-1 through one read port and one compare
//   unit, one slot a cycle. req_ready returns in the same cycle as rsp_valid
//   rises, as the sequencer leaves its final step and the result loads.
//   A stalled result holds the sequencer in its final step; the table is
//   updated when the result loads, and the next command is taken while that
//   result still waits to transfer. Reset (synchronous): slot 0 runnable,
//   others free, current slot 0, one live slot, next id 1, round-robin
//   policy; per-slot valid bits clear the slot states at once.
// ----------------------------------------------------------------------------
`include "thread_slot_scheduler_defines.svh"

module thread_slot_scheduler import tss_pkg::*; #(
   parameter int SLOTS         = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_priority_req,
   input  logic [31:0] req_timestamp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [15:0] rsp_thread_id,
   output logic [4:0]  rsp_live_count
);

   localparam int IDX_W      = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int PRIO_EXT_W = (PRIORITY_BITS > 8) ? PRIORITY_BITS : 8;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(SLOTS);

   // control registers
   seq_state_type      seq_ff, seq_in;
   logic [1:0]         alg_ff;
   logic [IDX_W-1:0]   cur_ff;
   logic [CNT_W-1:0]   occ_ff;
   logic [15:0]        next_id_ff;
   logic               smp_vld_ff;
   logic               rsp_valid_ff;

   // command and scan registers
   cmd_type                  cmd_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;
   logic [31:0]              time_ff;
   status_type               status_ff;
   slot_state_type           want_ff;
   logic [1:0]               mode_ff;
   logic [IDX_W-1:0]         rd_addr_ff;
   logic [IDX_W-1:0]         issued_ff;
   logic [IDX_W-1:0]         smp_idx_ff;

   // slot memories and registered read data
   slot_state_type           state_mem [SLOTS];
   logic [PRIORITY_BITS-1:0] prio_mem  [SLOTS];
   logic [31:0]              time_mem  [SLOTS];
   logic [15:0]              ident_mem [SLOTS];
   logic [SLOTS-1:0]         state_vld_ff;
   slot_state_type           st_rd_ff;
   logic                     stv_rd_ff;
   logic [PRIORITY_BITS-1:0] prio_rd_ff;
   logic [31:0]              time_rd_ff;
   logic [15:0]              id_rd_ff;

   // output registers
   status_type  rsp_status_ff;
   logic [3:0]  rsp_slot_ff;
   logic [15:0] rsp_id_ff;
   logic [4:0]  rsp_live_ff;

   // combinational control
   logic                  accept;
   logic                  yd_cmd;
   logic                  sched_skip;
   logic                  issue;
   logic                  scan_done;
   logic                  scan_begin;
   logic                  restart;
   logic                  fin_go;
   logic                  res_ok;
   logic                  rd_en;
   logic                  wr_en;
   logic                  wr_entry;
   slot_state_type        wr_state;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      tgt;
   logic [IDX_W-1:0]      start_rr;
   logic [IDX_W-1:0]      scan_start;
   logic [IDX_W-1:0]      rd_addr_next;
   logic [CNT_W-1:0]      occ_next;
   logic [15:0]           res_id;
   logic [IDX_W-1:0]      res_slot;
   logic [PRIO_EXT_W-1:0] prio_ext;
   slot_state_type        smp_state;
   pick_ctrl_type         pick_ctrl;
   logic                  pick_found;
   logic [IDX_W-1:0]      pick_best;

   assign prio_ext = PRIO_EXT_W'(req_priority_req);
   assign accept   = req_valid && req_ready;
   assign yd_cmd   = (cmd_ff == CMD_YIELD) || (cmd_ff == CMD_DESTROY);
   assign tgt      = yd_cmd ? cur_ff : pick_best;
   assign start_rr = (cur_ff == LAST_IDX) ? FIRST_IDX : cur_ff + 1'b1;
   assign rd_addr_next = (rd_addr_ff == LAST_IDX) ? FIRST_IDX : rd_addr_ff + 1'b1;
   assign sched_skip = (occ_ff <= CNT_ONE) ||
                       ((alg_ff != ALG_RR) && (alg_ff != ALG_PRIO) && (alg_ff != ALG_FCFS));
   assign scan_done = (seq_ff == SEQ_SCAN) && (issued_ff == LAST_IDX) && !smp_vld_ff;

   // an unwritten slot reads as its reset state
   assign smp_state = stv_rd_ff ? st_rd_ff :
                      ((smp_idx_ff == '0) ? ST_RUN : ST_FREE);

   // sequencer next state
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_command))
                  CMD_CREATE: begin
                     seq_in = SEQ_SCAN;
                  end
                  CMD_YIELD, CMD_DESTROY: begin
                     seq_in = (cur_ff == '0) ? SEQ_FINISH : SEQ_READ;
                  end
                  default: begin
                     seq_in = sched_skip ? SEQ_FINISH : SEQ_SCAN;
                  end
               endcase
            end
         end
         SEQ_SCAN: begin
            if (scan_done) begin
               if (cmd_ff == CMD_CREATE) begin
                  seq_in = SEQ_FINISH;
               end else if (pick_found) begin
                  seq_in = SEQ_READ;
               end else if (want_ff == ST_RUN) begin
                  seq_in = SEQ_SCAN;
               end else begin
                  seq_in = SEQ_FINISH;
               end
            end
         end
         SEQ_READ: begin
            seq_in = SEQ_FINISH;
         end
         default: begin
            if (!rsp_valid_ff || rsp_ready) begin
               seq_in = SEQ_IDLE;
            end
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = seq_ff == SEQ_IDLE;
      issue      = (seq_ff == SEQ_SCAN) && (issued_ff != LAST_IDX);
      restart    = scan_done && (cmd_ff == CMD_SCHED) && !pick_found &&
                   (want_ff == ST_RUN);
      scan_begin = (accept && ((cmd_type'(req_command) == CMD_CREATE) ||
                              ((cmd_type'(req_command) == CMD_SCHED) && !sched_skip))) ||
                   restart;
      fin_go     = (seq_ff == SEQ_FINISH) && (!rsp_valid_ff || rsp_ready);
      rd_en      = issue || (seq_ff == SEQ_READ);
      rd_addr    = (seq_ff == SEQ_READ) ? tgt : rd_addr_ff;
      if (accept) begin
         scan_start = ((cmd_type'(req_command) == CMD_SCHED) && (alg_ff == ALG_RR)) ?
                      start_rr : FIRST_IDX;
      end else begin
         scan_start = (mode_ff == ALG_RR) ? start_rr : FIRST_IDX;
      end
      pick_ctrl.clear  = scan_begin;
      pick_ctrl.sample = smp_vld_ff;
      pick_ctrl.want   = want_ff;
      pick_ctrl.mode   = mode_ff;
   end

   // result and table update for the finishing command
   always_comb begin
      res_ok   = status_ff == STATUS_OK;
      res_slot = res_ok ? tgt : '0;
      res_id   = !res_ok ? 16'd0 : ((cmd_ff == CMD_CREATE) ? next_id_ff : id_rd_ff);
      occ_next = occ_ff;
      wr_state = ST_RUN;
      wr_en    = 1'b0;
      wr_entry = 1'b0;
      if (res_ok) begin
         case (cmd_ff)
            CMD_CREATE: begin
               occ_next = occ_ff + CNT_ONE;
               wr_en    = fin_go;
               wr_entry = fin_go;
            end
            CMD_YIELD: begin
               wr_state = ST_YIELD;
               wr_en    = fin_go;
            end
            CMD_DESTROY: begin
               occ_next = occ_ff - CNT_ONE;
               wr_state = ST_FREE;
               wr_en    = fin_go;
            end
            default: begin
               wr_en = fin_go && (want_ff == ST_YIELD);
            end
         endcase
      end
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         alg_ff       <= ALG_RR;
         cur_ff       <= '0;
         occ_ff       <= CNT_ONE;
         next_id_ff   <= 16'd1;
         smp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff     <= seq_in;
         smp_vld_ff <= issue;
         if (csr_write_enable) begin
            alg_ff <= csr_write_data;
         end
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
            occ_ff       <= occ_next;
            if (res_ok && (cmd_ff == CMD_CREATE)) begin
               next_id_ff <= next_id_ff + 16'd1;
            end
            if (res_ok && (cmd_ff == CMD_DESTROY)) begin
               cur_ff <= '0;
            end
            if (res_ok && (cmd_ff == CMD_SCHED)) begin
               cur_ff <= tgt;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture the command and step the scan
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= cmd_type'(req_command);
         prio_ff <= prio_ext[PRIORITY_BITS-1:0];
         time_ff <= req_timestamp;
         want_ff <= (cmd_type'(req_command) == CMD_CREATE) ? ST_FREE : ST_RUN;
         mode_ff <= (cmd_type'(req_command) == CMD_CREATE) ? ALG_RR : alg_ff;
         case (cmd_type'(req_command))
            CMD_CREATE: begin
               status_ff <= STATUS_FULL;
            end
            CMD_YIELD, CMD_DESTROY: begin
               status_ff <= (cur_ff == '0) ? STATUS_REFUSED : STATUS_OK;
            end
            default: begin
               status_ff <= STATUS_NONE;
            end
         endcase
      end else if (scan_done && pick_found) begin
         status_ff <= STATUS_OK;
      end
      if (restart) begin
         want_ff <= ST_YIELD;
      end
      if (scan_begin) begin
         rd_addr_ff <= scan_start;
         issued_ff  <= '0;
      end else if (issue) begin
         rd_addr_ff <= rd_addr_next;
         issued_ff  <= issued_ff + 1'b1;
      end
      if (issue) begin
         smp_idx_ff <= rd_addr_ff;
      end
   end

   // load the output register
   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= 4'(res_slot);
         rsp_id_ff     <= res_id;
         rsp_live_ff   <= 5'(occ_next);
      end
   end

   // mark written slot states
   always_ff @(posedge clock) begin
      if (reset) begin
         state_vld_ff <= '0;
      end else if (wr_en) begin
         state_vld_ff[tgt] <= 1'b1;
      end
   end

   // slot memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[tgt] <= wr_state;
      end
      if (wr_entry) begin
         prio_mem[tgt]  <= prio_ff;
         time_mem[tgt]  <= time_ff;
         ident_mem[tgt] <= next_id_ff;
      end
      if (rd_en) begin
         st_rd_ff   <= state_mem[rd_addr];
         stv_rd_ff  <= state_vld_ff[rd_addr];
         prio_rd_ff <= prio_mem[rd_addr];
         time_rd_ff <= time_mem[rd_addr];
         id_rd_ff   <= ident_mem[rd_addr];
      end
   end

   tss_pick_unit #(
      .IDX_W         (IDX_W),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_pick (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pick_ctrl),
      .smp_idx   (smp_idx_ff),
      .smp_state (smp_state),
      .smp_prio  (prio_rd_ff),
      .smp_time  (time_rd_ff),
      .found     (pick_found),
      .best_idx  (pick_best)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_thread_id  = rsp_id_ff;
   assign rsp_live_count = rsp_live_ff;

   `TSS_ASSERT_NEXT(a_busy_after_accept, accept, !req_ready, "ready high right after accept")
   `TSS_ASSERT_NEXT(a_result_loaded, fin_go, rsp_valid, "finished command gave no result")
   `TSS_ASSERT_SAME(a_occ_range, 1'b1, (occ_ff != '0) && (occ_ff <= CNT_MAX), "bad live count")

endmodule

[rtl/core/tss_pick_unit.sv]
// ----------------------------------------------------------------------------
// Thread slot pick unit
// Shared compare unit: takes one slot per sample and keeps the best match
// under first-match, highest-priority or earliest-time selection.
// ----------------------------------------------------------------------------
module tss_pick_unit import tss_pkg::*; #(
   parameter int IDX_W         = 4,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pick_ctrl_type            ctrl,
   input  logic [IDX_W-1:0]         smp_idx,
   input  slot_state_type           smp_state,
   input  logic [PRIORITY_BITS-1:0] smp_prio,
   input  logic [31:0]              smp_time,
   output logic                     found,
   output logic [IDX_W-1:0]         best_idx
);

   logic                     found_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [PRIORITY_BITS-1:0] best_prio_ff;
   logic [31:0]              best_time_ff;
   logic                     better;
   logic                     take;

   // compare the sample against the best so far
   always_comb begin
      case (ctrl.mode)
         ALG_PRIO: begin
            better = (smp_prio > best_prio_ff) ||
                     ((smp_prio == best_prio_ff) && (smp_time < best_time_ff));
         end
         ALG_FCFS: begin
            better = smp_time < best_time_ff;
         end
         default: begin
            better = 1'b0;
         end
      endcase
      take = ctrl.sample && (smp_state == ctrl.want) && (!found_ff || better);
   end

   // hold the found flag
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   // hold the best candidate
   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff  <= smp_idx;
         best_prio_ff <= smp_prio;
         best_time_ff <= smp_time;
      end
   end

   assign found    = found_ff;
   assign best_idx = best_idx_ff;

endmodule

[tb/sv/tb_thread_slot_scheduler.sv]
// ----------------------------------------------------------------------------
// Thread slot scheduler testbench
// Drives create, yield, destroy and schedule commands under every selection
// policy code, with random sender gaps and receiver stalls, and checks each
// result against an in-bench prediction of the slot table.
// ----------------------------------------------------------------------------
module tb_thread_slot_scheduler import tss_pkg::*; ;

   localparam int SLOTS = 16;
   localparam int PHASE_ITEMS = 200;
   localparam int SETTLE_CYCLES = 2 * SLOTS + 10;
   localparam int CYCLE_LIMIT = 1_000_000;

   // the fourth policy code, which selects nothing
   localparam logic [1:0] ALG_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot;
      logic [15:0] thread_id;
      logic [4:0]  live_count;
   } sched_result_type;

   // -------------------------------------------------------------------------
   // Slot table prediction and result checking
   // -------------------------------------------------------------------------
   class sched_scoreboard;
      slot_state_type   slot_st[SLOTS];
      logic [7:0]       slot_prio[SLOTS];
      logic [31:0]      slot_arrival[SLOTS];
      logic [15:0]      slot_id[SLOTS];
      int               cur_slot;
      int               live;
      logic [15:0]      next_id;
      logic [1:0]       policy;
      sched_result_type pending_results[$];
      int               fail_count;
      int               accepted;
      int               checked;
      int               full_seen;
      int               refused_seen;
      int               none_seen;

      function new();
         int i;
         for (i = 0; i < SLOTS; i++) begin
            slot_st[i] = ST_FREE;
            slot_prio[i] = '0;
            slot_arrival[i] = '0;
            slot_id[i] = '0;
         end
         slot_st[0] = ST_RUN;
         cur_slot = 0;
         live = 1;
         next_id = 16'd1;
         policy = ALG_RR;
         fail_count = 0;
         accepted = 0;
         checked = 0;
         full_seen = 0;
         refused_seen = 0;
         none_seen = 0;
      endfunction

      function void set_policy(logic [1:0] alg);
         policy = alg;
      endfunction

      // choose among slots 1..SLOTS-1 in the given state, -1 if none
      function int pick_slot(slot_state_type want);
         int best;
         int i;
         best = -1;
         if (policy == ALG_RR) begin
            for (i = cur_slot + 1; i < SLOTS; i++)
               if (slot_st[i] == want) return i;
            for (i = 1; i <= cur_slot; i++)
               if (slot_st[i] == want) return i;
            return -1;
         end
         for (i = 1; i < SLOTS; i++) begin
            if (slot_st[i] == want) begin
               if (best < 0) begin
                  best = i;
               end else if (policy == ALG_PRIO) begin
                  if (slot_prio[i] > slot_prio[best])
                     best = i;
                  else if (slot_prio[i] == slot_prio[best] &&
                           slot_arrival[i] < slot_arrival[best])
                     best = i;
               end else if (slot_arrival[i] < slot_arrival[best]) begin
                  best = i;
               end
            end
         end
         return best;
      endfunction

      // advance the table for one accepted command and queue its result
      function void note_command(cmd_type cmd, logic [7:0] prio, logic [31:0] stamp);
         sched_result_type res;
         int chosen;
         int i;
         bit done;
         res = '0;
         res.status = STATUS_OK;
         accepted++;
         case (cmd)
            CMD_CREATE: begin
               res.status = STATUS_FULL;
               done = 1'b0;
               for (i = 1; i < SLOTS && !done; i++) begin
                  if (slot_st[i] == ST_FREE) begin
                     slot_st[i] = ST_RUN;
                     slot_id[i] = next_id;
                     next_id = next_id + 16'd1;
                     slot_prio[i] = prio;
                     slot_arrival[i] = stamp;
                     live++;
                     res.status = STATUS_OK;
                     res.slot = 4'(i);
                     res.thread_id = slot_id[i];
                     done = 1'b1;
                  end
               end
            end
            CMD_YIELD, CMD_DESTROY: begin
               if (cur_slot == 0) begin
                  res.status = STATUS_REFUSED;
               end else begin
                  res.slot = 4'(cur_slot);
                  res.thread_id = slot_id[cur_slot];
                  if (cmd == CMD_YIELD) begin
                     slot_st[cur_slot] = ST_YIELD;
                  end else begin
                     slot_st[cur_slot] = ST_FREE;
                     if (live > 0) live--;
                     cur_slot = 0;
                  end
               end
            end
            default: begin
               chosen = -1;
               if (live > 1 && policy != ALG_NONE) begin
                  chosen = pick_slot(ST_RUN);
                  if (chosen < 0) begin
                     chosen = pick_slot(ST_YIELD);
                     if (chosen >= 0) slot_st[chosen] = ST_RUN;
                  end
               end
               if (chosen < 0) begin
                  res.status = STATUS_NONE;
               end else begin
                  cur_slot = chosen;
                  res.slot = 4'(chosen);
                  res.thread_id = slot_id[chosen];
               end
            end
         endcase
         res.live_count = 5'(live);
         case (res.status)
            STATUS_FULL:    full_seen++;
            STATUS_REFUSED: refused_seen++;
            STATUS_NONE:    none_seen++;
            default: ;
         endcase
         pending_results.push_back(res);
      endfunction

      // compare one transferred result with the oldest prediction
      function void check_result(logic [1:0] status, logic [3:0] slot,
                                 logic [15:0] thread_id, logic [4:0] live_count);
         sched_result_type want;
         if (pending_results.size() == 0) begin
            $error("result transfer with no command pending");
            fail_count++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            fail_count++;
         end
         if (slot !== want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want.slot, slot);
            fail_count++;
         end
         if (thread_id !== want.thread_id) begin
            $error("thread_id mismatch: expected %0d, actual %0d", want.thread_id, thread_id);
            fail_count++;
         end
         if (live_count !== want.live_count) begin
            $error("live_count mismatch: expected %0d, actual %0d",
                   want.live_count, live_count);
            fail_count++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = '0;
   logic [7:0]  req_priority_req = '0;
   logic [31:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_slot;
   logic [15:0] rsp_thread_id;
   logic [4:0]  rsp_live_count;

   bit          idle_on = 1'b1;
   int          cycle_count = 0;
   int          policies_run = 0;

   sched_scoreboard board = new();

   thread_slot_scheduler #(
      .SLOTS         (SLOTS),
      .PRIORITY_BITS (8)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_priority_req (req_priority_req),
      .req_timestamp    (req_timestamp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_thread_id    (rsp_thread_id),
      .rsp_live_count   (rsp_live_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Command side
   // -------------------------------------------------------------------------
   // hold one command on the request channel until it transfers
   task automatic send_command(cmd_type cmd, logic [7:0] prio, logic [31:0] stamp);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_priority_req <= prio;
      req_timestamp <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_command(cmd, prio, stamp);
   endtask

   // random command; priorities and times often repeat to force ties
   task automatic send_random(int create_pct);
      int pick;
      cmd_type cmd;
      logic [7:0] prio;
      logic [31:0] stamp;
      if ($urandom_range(0, 99) < create_pct) begin
         cmd = CMD_CREATE;
      end else begin
         pick = $urandom_range(0, 3);
         cmd = (pick == 0) ? CMD_YIELD : (pick == 1) ? CMD_DESTROY : CMD_SCHED;
      end
      if ($urandom_range(0, 1) == 0) begin
         prio = 8'($urandom);
      end else begin
         case ($urandom_range(0, 3))
            0: prio = 8'h00;
            1: prio = 8'hff;
            2: prio = 8'h80;
            default: prio = 8'h01;
         endcase
      end
      if ($urandom_range(0, 4) < 3) begin
         stamp = $urandom;
      end else begin
         case ($urandom_range(0, 3))
            0: stamp = 32'h0000_0000;
            1: stamp = 32'hffff_ffff;
            2: stamp = 32'd100;
            default: stamp = 32'd101;
         endcase
      end
      send_command(cmd, prio, stamp);
   endtask

   // drop valid, wait for every result, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_policy(logic [1:0] alg);
      csr_write_enable <= 1'b1;
      csr_write_data <= alg;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_policy(alg);
      policies_run++;
   endtask

   // -------------------------------------------------------------------------
   // Result side: check transfers, stall in random bursts
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_result(rsp_status, rsp_slot, rsp_thread_id, rsp_live_count);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [1:0] phase_alg[7];
      int         phase_create[7];
      int         p;
      int         n;
      phase_alg = '{ALG_RR, ALG_PRIO, ALG_FCFS, ALG_NONE, ALG_PRIO, ALG_FCFS, ALG_RR};
      phase_create = '{45, 30, 60, 40, 50, 35, 45};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // scheduler current and alone: refusals and nothing to schedule
      send_command(CMD_YIELD, 8'h00, 32'h0);
      send_command(CMD_DESTROY, 8'hff, 32'hffff_ffff);
      send_command(CMD_SCHED, 8'h00, 32'h0);
      // field extremes on create
      send_command(CMD_CREATE, 8'hff, 32'h0000_0000);
      send_command(CMD_CREATE, 8'h00, 32'hffff_ffff);
      send_command(CMD_CREATE, 8'h5a, 32'ha5a5_a5a5);
      // walk round robin, yield every thread, then fall back to yielded slots
      send_command(CMD_SCHED, 8'h00, 32'h0);
      send_command(CMD_YIELD, 8'h00, 32'h0);
      send_command(CMD_SCHED, 8'h00, 32'h0);
      send_command(CMD_YIELD, 8'h00, 32'h0);
      send_command(CMD_SCHED, 8'h00, 32'h0);
      send_command(CMD_YIELD, 8'h00, 32'h0);
      send_command(CMD_SCHED, 8'h00, 32'h0);
      // destroy down to the scheduler alone
      send_command(CMD_DESTROY, 8'h00, 32'h0);
      send_command(CMD_SCHED, 8'h00, 32'h0);
      send_command(CMD_DESTROY, 8'h00, 32'h0);
      send_command(CMD_SCHED, 8'h00, 32'h0);
      send_command(CMD_DESTROY, 8'h00, 32'h0);
      send_command(CMD_SCHED, 8'h00, 32'h0);

      // random phases, one policy setting each; the last runs without idling
      for (p = 0; p < 7; p++) begin
         wait_idle();
         write_policy(phase_alg[p]);
         idle_on = (p != 6);
         for (n = 0; n < PHASE_ITEMS; n++)
            send_random(phase_create[p]);
      end

      wait_idle();
      if (board.pending_results.size() != 0) begin
         $error("%0d results never arrived", board.pending_results.size());
         board.fail_count++;
      end

      $display("Covered %0d commands and %0d results over %0d policy writes, unused code too.",
               board.accepted, board.checked, policies_run);
      $display("Seen: %0d table full, %0d scheduler refusals, %0d empty schedules.",
               board.full_seen, board.refused_seen, board.none_seen);
      if (board.fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[thread_slot_scheduler.f]
+incdir+rtl/core
rtl/core/tss_pkg.sv
rtl/core/tss_pick_unit.sv
rtl/core/thread_slot_scheduler.sv
tb/sv/tb_thread_slot_scheduler.sv
